>>> rtl/group_reverse_reorder_macros.svh
// Assertion macros used by the checker file of this block.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef GROUP_REVERSE_REORDER_MACROS_SVH
`define GROUP_REVERSE_REORDER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define GRR_ASSERT_IMP(lbl, clk, rst_n, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define GRR_ASSERT_NXT(lbl, clk, rst_n, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error(msg);

// Next-cycle implication that is also checked through reset.
`define GRR_ASSERT_NXT_ALWAYS(lbl, clk, a, b, msg) \
    lbl: assert property (@(posedge clk) (a) |=> (b)) \
        else $error(msg);

`endif

>>> rtl/grr_pkg.sv
// ----------------------------------------------------------------------------
// grr_pkg
// Constants and shared types of the group reverse reorder block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package grr_pkg;

    localparam int MAX_GROUP = 16;
    localparam int DATA_W    = 32;
    localparam int GS_W      = 5;
    localparam int IDX_W     = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
    localparam int CNT_W     = $clog2(MAX_GROUP + 1);
    localparam int ADDR_W    = IDX_W + 1;
    localparam int RAM_DEPTH = 1 << ADDR_W;
    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    localparam logic [GS_W-1:0] GS_RESET = GS_W'(2);

    // One finished group, handed from the fill side to the drain side.
    typedef struct packed {
        logic             bank;
        logic [CNT_W-1:0] count;
        logic             rev;
        logic             last;
    } t_desc;

    // The drain side gives a bank back once its last word has been read.
    typedef struct packed {
        logic valid;
        logic bank;
    } t_release;

endpackage

`default_nettype wire

>>> rtl/grr_ram.sv
// ----------------------------------------------------------------------------
// grr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module grr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/grr_queue.sv
// ----------------------------------------------------------------------------
// grr_queue
// Short queue of group descriptors between the fill and drain sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module grr_queue
    import grr_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_desc i_data,
    output logic       o_ready,
    input  wire logic  i_pop,
    output logic       o_valid,
    output t_desc      o_data
);

    t_desc              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr, n_wr;
    logic [Q_PTR_W-1:0] r_rd, n_rd;
    logic [Q_CNT_W-1:0] r_cnt, n_cnt;

    function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
        if (p == Q_PTR_W'(Q_DEPTH - 1)) begin
            return '0;
        end
        return p + Q_PTR_W'(1);
    endfunction

    assign o_ready = (r_cnt != Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = ptr_inc(r_wr);
        end
        if (i_pop) begin
            n_rd = ptr_inc(r_rd);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + Q_CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/grr_front.sv
// ----------------------------------------------------------------------------
// grr_front
// Fill side: holds the group size, writes words into a free bank and closes
// a group when it is full or the sequence ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module grr_front
    import grr_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_valid,
    input  wire logic        [GS_W-1:0]   i_group_size,
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire logic signed [DATA_W-1:0] i_item_value,
    input  wire logic                     i_sequence_end,
    output logic                          o_wr_en,
    output logic             [ADDR_W-1:0] o_wr_addr,
    output logic             [DATA_W-1:0] o_wr_data,
    output logic                          o_push,
    output t_desc                         o_desc,
    input  wire logic                     i_q_ready,
    input  wire t_release                 i_release
);

    logic [GS_W-1:0]  r_group_size;
    logic [CNT_W-1:0] r_fill, n_fill;
    logic             r_wbank, n_wbank;
    logic [1:0]       r_busy, n_busy;
    logic [CNT_W-1:0] eff_size;
    logic [CNT_W-1:0] fill_inc;
    logic             accept;
    logic             close;

    // Size zero behaves as one; sizes above the bank depth saturate.
    always_comb begin
        if (r_group_size == '0) begin
            eff_size = CNT_W'(1);
        end else if (32'(r_group_size) > 32'(MAX_GROUP)) begin
            eff_size = CNT_W'(MAX_GROUP);
        end else begin
            eff_size = CNT_W'(r_group_size);
        end
    end

    assign o_ready  = !r_busy[r_wbank] && i_q_ready;
    assign accept   = i_valid && o_ready;
    assign fill_inc = r_fill + CNT_W'(1);
    assign close    = accept && ((fill_inc >= eff_size) || i_sequence_end);

    assign o_wr_en   = accept;
    assign o_wr_addr = {r_wbank, r_fill[IDX_W-1:0]};
    assign o_wr_data = DATA_W'(unsigned'(i_item_value));

    assign o_push       = close;
    assign o_desc.bank  = r_wbank;
    assign o_desc.count = fill_inc;
    assign o_desc.rev   = (fill_inc >= eff_size);
    assign o_desc.last  = i_sequence_end;

    always_comb begin
        n_fill  = r_fill;
        n_wbank = r_wbank;
        n_busy  = r_busy;
        if (i_release.valid) begin
            n_busy[i_release.bank] = 1'b0;
        end
        if (close) begin
            n_fill          = '0;
            n_wbank         = !r_wbank;
            n_busy[r_wbank] = 1'b1;
        end else if (accept) begin
            n_fill = fill_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_size <= GS_RESET;
            r_fill       <= '0;
            r_wbank      <= 1'b0;
            r_busy       <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_group_size <= i_group_size;
            end
            r_fill  <= n_fill;
            r_wbank <= n_wbank;
            r_busy  <= n_busy;
        end
    end

endmodule

`default_nettype wire

>>> rtl/grr_back.sv
// ----------------------------------------------------------------------------
// grr_back
// Drain side: takes closed groups from the queue and reads their words out
// of the bank in run order, one read per cycle when the output can move.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module grr_back
    import grr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_q_valid,
    input  wire t_desc       i_q_desc,
    output logic             o_q_pop,
    output t_release         o_release,
    output logic             o_rd_en,
    output logic [ADDR_W-1:0] o_rd_addr,
    input  wire logic        i_out_ready,
    output logic             o_out_valid,
    output logic             o_run_last,
    output logic             o_sequence_done
);

    typedef enum logic [1:0] {
        BS_IDLE = 2'b01,
        BS_RUN  = 2'b10
    } t_back_state;

    t_back_state      r_state, n_state;
    t_desc            r_desc;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic             r_s1_valid, n_s1_valid;
    logic             r_s1_last, n_s1_last;
    logic             r_s1_done, n_s1_done;
    logic             issue;
    logic             issue_final;
    logic             load;
    logic [CNT_W-1:0] last_idx;
    logic [CNT_W-1:0] sel_idx;

    // The read data register inside the RAM is the output register, so a
    // new read may only be issued when its current word is empty or leaving.
    assign last_idx    = r_desc.count - CNT_W'(1);
    assign issue       = (r_state == BS_RUN) && (!r_s1_valid || i_out_ready);
    assign issue_final = issue && (r_idx == last_idx);
    assign load        = i_q_valid && ((r_state == BS_IDLE) || issue_final);
    assign sel_idx     = r_desc.rev ? (last_idx - r_idx) : r_idx;

    assign o_q_pop         = load;
    assign o_release.valid = issue_final;
    assign o_release.bank  = r_desc.bank;
    assign o_rd_en         = issue;
    assign o_rd_addr       = {r_desc.bank, sel_idx[IDX_W-1:0]};
    assign o_out_valid     = r_s1_valid;
    assign o_run_last      = r_s1_last;
    assign o_sequence_done = r_s1_done;

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_s1_valid = r_s1_valid;
        n_s1_last  = r_s1_last;
        n_s1_done  = r_s1_done;
        if (issue) begin
            n_idx      = r_idx + CNT_W'(1);
            n_s1_valid = 1'b1;
            n_s1_last  = issue_final;
            n_s1_done  = issue_final && r_desc.last;
        end else if (i_out_ready) begin
            n_s1_valid = 1'b0;
        end
        if (load) begin
            n_state = BS_RUN;
            n_idx   = '0;
        end else if (issue_final) begin
            n_state = BS_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= BS_IDLE;
            r_idx      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_last <= n_s1_last;
        r_s1_done <= n_s1_done;
        if (load) begin
            r_desc <= i_q_desc;
        end
    end

endmodule

`default_nettype wire

>>> rtl/group_reverse_reorder.sv
// ----------------------------------------------------------------------------
// group_reverse_reorder
// Reverses a stream of signed 32-bit words in groups of a programmable size.
// ----------------------------------------------------------------------------
// Usage:
// Input words arrive on i_valid / o_ready with i_item_value and
// i_sequence_end, the latter marking the final word of a sequence. Output
// words leave on o_valid / i_ready with o_out_value, o_run_last (last word
// of a run) and o_sequence_done (final word of the sequence). The group size
// is written on i_cfg_valid / o_cfg_ready; o_cfg_ready is always high and
// writes are meant to happen only while the block is idle.
// A full group comes out newest word first; a partial group closed by the
// end flag comes out in arrival order. Size one passes words straight on.
// The word that closes a group sends its descriptor through the queue and
// the drain state register, and the first word of the run then comes from
// the registered RAM read. Two banks let one group fill while the other
// drains, one word per cycle on each side while the fill bank is free and
// the output is not stalled; the RAM has a single read port.
// Reset clears the fill count, the bank flags, the queue and the output
// valid, and sets the group size to two. When the receiver stalls the output
// word holds, draining pauses, and the fill side keeps accepting until both
// banks are waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module group_reverse_reorder
    import grr_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // Configuration write channel.
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic        [GS_W-1:0]   i_group_size,
    // Input word channel.
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire logic signed [DATA_W-1:0] i_item_value,
    input  wire logic                     i_sequence_end,
    // Output word channel.
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output logic signed      [DATA_W-1:0] o_out_value,
    output logic                          o_run_last,
    output logic                          o_sequence_done
);

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [DATA_W-1:0] rd_data;
    logic              q_push;
    logic              q_ready;
    logic              q_pop;
    logic              q_valid;
    t_desc             push_desc;
    t_desc             head_desc;
    t_release          bank_release;

    // Configuration is taken at any cycle.
    assign o_cfg_ready = 1'b1;

    // The fill side writes words into the bank it owns and posts a
    // descriptor once the group is closed.
    grr_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_group_size   (i_group_size),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_item_value   (i_item_value),
        .i_sequence_end (i_sequence_end),
        .o_wr_en        (wr_en),
        .o_wr_addr      (wr_addr),
        .o_wr_data      (wr_data),
        .o_push         (q_push),
        .o_desc         (push_desc),
        .i_q_ready      (q_ready),
        .i_release      (bank_release)
    );

    grr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (push_desc),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (head_desc)
    );

    // Two banks of MAX_GROUP words each; the bank is the top address bit.
    grr_ram #(
        .WIDTH (DATA_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // The drain side reads each group in run order and gives the bank back
    // as soon as its last word has been read.
    grr_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_q_desc        (head_desc),
        .o_q_pop         (q_pop),
        .o_release       (bank_release),
        .o_rd_en         (rd_en),
        .o_rd_addr       (rd_addr),
        .i_out_ready     (i_ready),
        .o_out_valid     (o_valid),
        .o_run_last      (o_run_last),
        .o_sequence_done (o_sequence_done)
    );

    assign o_out_value = signed'(rd_data);

endmodule

`default_nettype wire

>>> rtl/grr_checker.sv
// ----------------------------------------------------------------------------
// grr_checker
// Port-level checks of the group reverse reorder block, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "group_reverse_reorder_macros.svh"

module grr_checker
    import grr_pkg::*;
(
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     o_valid,
    input wire logic                     i_ready,
    input wire logic signed [DATA_W-1:0] o_out_value,
    input wire logic                     o_run_last,
    input wire logic                     o_sequence_done
);

    // The end of a sequence always closes a run.
    `GRR_ASSERT_IMP(a_done_is_run_last, i_clk, i_rst_n, o_valid && o_sequence_done, o_run_last, "sequence_done without run_last")

    // Reset empties the output side on the next edge.
    `GRR_ASSERT_NXT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n, !o_valid, "output valid after reset")

    // A stalled output word stays offered.
    `GRR_ASSERT_NXT(a_out_held, i_clk, i_rst_n, o_valid && !i_ready, o_valid, "output valid dropped")

    // A stalled output word keeps its payload.
    `GRR_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, o_valid && !i_ready, $stable(o_out_value) && $stable(o_run_last) && $stable(o_sequence_done), "output payload changed")

endmodule

bind group_reverse_reorder grr_checker u_grr_checker (.*);

`default_nettype wire
